// ----- sv/dsr_pkg.sv -----
// Shared types and constants of the duty step regulator.
`timescale 1ns / 1ps
`default_nettype none

package dsr_pkg;

    // Command codes carried in the cmd field of an input word.
    localparam logic [1:0] CMD_ADJUST = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_TARGET  = 3'd0;
    localparam logic [2:0] REG_WINDOW  = 3'd1;
    localparam logic [2:0] REG_FAST    = 3'd2;
    localparam logic [2:0] REG_SSTEP   = 3'd3;
    localparam logic [2:0] REG_FSTEP   = 3'd4;
    localparam logic [2:0] REG_MIN     = 3'd5;
    localparam logic [2:0] REG_MAX     = 3'd6;
    localparam logic [2:0] REG_CAL     = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_TARGET = 16'd0;
    localparam logic [15:0] RST_WINDOW = 16'd655;
    localparam logic [15:0] RST_FAST   = 16'd3277;
    localparam logic [15:0] RST_SSTEP  = 16'd66;
    localparam logic [15:0] RST_FSTEP  = 16'd655;
    localparam logic [15:0] RST_MIN    = 16'd0;
    localparam logic [15:0] RST_MAX    = 16'd58982;
    localparam logic [15:0] RST_CAL    = 16'd0;

    // Configuration port widths.
    localparam int ADDR_W = 5;
    localparam int PDATA_W = 32;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // Operand selections of the shared multiplier.
    localparam logic [2:0] MUL_GAIN = 3'd0;
    localparam logic [2:0] MUL_LO   = 3'd1;
    localparam logic [2:0] MUL_HI   = 3'd2;
    localparam logic [2:0] MUL_FLO  = 3'd3;
    localparam logic [2:0] MUL_FHI  = 3'd4;

    // Configuration register file contents.
    typedef struct packed {
        logic [15:0]        target_mv;
        logic [15:0]        window_fraction;
        logic [15:0]        fast_fraction;
        logic [15:0]        slow_step;
        logic [15:0]        fast_step;
        logic [15:0]        min_duty;
        logic [15:0]        max_duty;
        logic signed [15:0] calibration_mv;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       load_meas;
        logic       load_delta;
        logic       commit;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic adjust_run;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- sv/dsr_if.sv -----
// Handshake interfaces for the input and result channels.
`timescale 1ns / 1ps
`default_nettype none

interface dsr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [11:0] adc_mv;

    modport source (output valid, output cmd, output adc_mv, input ready);
    modport sink (input valid, input cmd, input adc_mv, output ready);
endinterface

interface dsr_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] measured_mv;
    logic [15:0] tracked_duty;
    logic [15:0] pwm_duty;
    logic        duty_written;
    logic        running;

    modport source (output valid, output measured_mv, output tracked_duty,
                    output pwm_duty, output duty_written, output running,
                    input ready);
    modport sink (input valid, input measured_mv, input tracked_duty,
                  input pwm_duty, input duty_written, input running,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/dc_dc_duty_step_regulator.sv -----
// Top level of the dead-band two-speed duty step regulator.
//
//   channel  | direction | handshake        | payload
//   ---------+-----------+------------------+------------------------------------------
//   req      | in        | valid / ready    | cmd, adc_mv
//   rsp      | out       | valid / ready    | measured_mv, tracked_duty, pwm_duty,
//            |           |                  | duty_written, running
//   apb      | in        | psel / penable   | paddr, pwdata, prdata (pready tied high)
//
// One word is in flight at a time. An adjust tick of a running regulator uses one shared
// 33x17 multiplier five times in a row, then a band compare and a duty update; start,
// stop and stopped adjust words use the multiplier once, for the gain, and then finish.
// A new word is accepted while the previous result still waits in the output register;
// a word finishes only once that register is free.
// Reset is asynchronous and active low and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module dc_dc_duty_step_regulator #(
    parameter int DIVIDER_GAIN_Q8 = 256
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dsr_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dsr_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    dsr_in_if.sink                            req,
    dsr_out_if.source                         rsp
);
    import dsr_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    // Configuration registers.
    dsr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    dsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // Arithmetic and regulator state.
    dsr_dp #(
        .DIVIDER_GAIN_Q8 (DIVIDER_GAIN_Q8)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (dp_cmd),
        .status       (dp_status),
        .in_cmd       (req.cmd),
        .in_adc_mv    (req.adc_mv),
        .measured_mv  (rsp.measured_mv),
        .tracked_duty (rsp.tracked_duty),
        .pwm_duty     (rsp.pwm_duty),
        .duty_written (rsp.duty_written),
        .running      (rsp.running)
    );

endmodule

`default_nettype wire

// ----- sv/dsr_regs.sv -----
// APB-style configuration register file.
`timescale 1ns / 1ps
`default_nettype none

module dsr_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [dsr_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [dsr_pkg::PDATA_W-1:0]  pwdata,
    output logic      [dsr_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output dsr_pkg::cfg_t                     cfg
);
    import dsr_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_mv       <= RST_TARGET;
            cfg_reg.window_fraction <= RST_WINDOW;
            cfg_reg.fast_fraction   <= RST_FAST;
            cfg_reg.slow_step       <= RST_SSTEP;
            cfg_reg.fast_step       <= RST_FSTEP;
            cfg_reg.min_duty        <= RST_MIN;
            cfg_reg.max_duty        <= RST_MAX;
            cfg_reg.calibration_mv  <= RST_CAL;
        end
        else if (wr_en)
        begin
            case (index)
                REG_TARGET: cfg_reg.target_mv       <= pwdata[15:0];
                REG_WINDOW: cfg_reg.window_fraction <= pwdata[15:0];
                REG_FAST:   cfg_reg.fast_fraction   <= pwdata[15:0];
                REG_SSTEP:  cfg_reg.slow_step       <= pwdata[15:0];
                REG_FSTEP:  cfg_reg.fast_step       <= pwdata[15:0];
                REG_MIN:    cfg_reg.min_duty        <= pwdata[15:0];
                REG_MAX:    cfg_reg.max_duty        <= pwdata[15:0];
                REG_CAL:    cfg_reg.calibration_mv  <= pwdata[15:0];
                default:    cfg_reg.target_mv       <= cfg_reg.target_mv;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb
    begin
        case (index)
            REG_TARGET: prdata = {16'd0, cfg_reg.target_mv};
            REG_WINDOW: prdata = {16'd0, cfg_reg.window_fraction};
            REG_FAST:   prdata = {16'd0, cfg_reg.fast_fraction};
            REG_SSTEP:  prdata = {16'd0, cfg_reg.slow_step};
            REG_FSTEP:  prdata = {16'd0, cfg_reg.fast_step};
            REG_MIN:    prdata = {16'd0, cfg_reg.min_duty};
            REG_MAX:    prdata = {16'd0, cfg_reg.max_duty};
            REG_CAL:    prdata = {16'd0, cfg_reg.calibration_mv};
            default:    prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/dsr_ctrl.sv -----
// Sequencing state machine of the duty step regulator.
`timescale 1ns / 1ps
`default_nettype none

module dsr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire dsr_pkg::dp_status_t status,
    output dsr_pkg::dp_cmd_t         cmd
);
    import dsr_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GAIN = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_HI   = 3'd3;
    localparam logic [2:0] S_FLO  = 3'd4;
    localparam logic [2:0] S_FHI  = 3'd5;
    localparam logic [2:0] S_CMP  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || out_ready;

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_GAIN;
                end
            end
            S_GAIN:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAIN;
                state_next  = status.adjust_run ? S_LO : S_FIN;
            end
            S_LO:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_LO;
                cmd.load_meas = 1'b1;
                state_next    = S_HI;
            end
            S_HI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_HI;
                state_next  = S_FLO;
            end
            S_FLO:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FLO;
                state_next  = S_FHI;
            end
            S_FHI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FHI;
                state_next  = S_CMP;
            end
            S_CMP:
            begin
                cmd.load_delta = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result slot fills on commit and empties when the word is taken.
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/dsr_dp.sv -----
// Datapath: shared multiplier, band decision, duty update and result register.
`timescale 1ns / 1ps
`default_nettype none

module dsr_dp #(
    parameter int DIVIDER_GAIN_Q8 = 256
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsr_pkg::cfg_t     cfg,
    input  wire dsr_pkg::dp_cmd_t  cmd,
    output dsr_pkg::dp_status_t    status,
    input  wire logic [1:0]        in_cmd,
    input  wire logic [11:0]       in_adc_mv,
    output logic [15:0]            measured_mv,
    output logic [15:0]            tracked_duty,
    output logic [15:0]            pwm_duty,
    output logic                   duty_written,
    output logic                   running
);
    import dsr_pkg::*;

    // Latched input word.
    logic [1:0]  cmd_reg;
    logic [11:0] adc_reg;

    // Multiplier results.
    logic [27:0]        scaled_reg;
    logic [15:0]        meas_reg;
    logic [32:0]        lo_num_reg;
    logic [32:0]        hi_num_reg;
    logic [MUL_P_W-1:0] fastlo_reg;
    logic [MUL_P_W-1:0] fasthi_reg;
    logic signed [16:0] delta_reg;

    // Regulator state.
    logic        run_reg;
    logic        run_next;
    logic [15:0] duty_reg;
    logic [15:0] duty_next;
    logic [15:0] applied_reg;
    logic [15:0] applied_next;
    logic [15:0] last_meas_reg;
    logic [15:0] last_meas_next;
    logic        written_next;

    // Result word.
    logic [15:0] out_meas_reg;
    logic [15:0] out_duty_reg;
    logic [15:0] out_pwm_reg;
    logic        out_written_reg;
    logic        out_run_reg;

    logic [MUL_A_W-1:0] op_a;
    logic [MUL_B_W-1:0] op_b;
    logic [MUL_P_W-1:0] product;
    logic signed [21:0] meas_sum;
    logic [15:0]        meas_sat;
    logic [49:0]        m_wide;
    logic [32:0]        m_narrow;
    logic signed [16:0] delta_next;
    logic signed [17:0] duty_sum;
    logic signed [17:0] duty_clamped;
    logic [15:0]        duty_new;

    assign status.adjust_run = (cmd_reg == CMD_ADJUST) && run_reg;

    // Operand selection of the shared multiplier.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_GAIN:
            begin
                op_a = {21'd0, adc_reg};
                op_b = 17'(DIVIDER_GAIN_Q8);
            end
            MUL_LO:
            begin
                op_a = {17'd0, cfg.target_mv};
                op_b = 17'h10000 - {1'b0, cfg.window_fraction};
            end
            MUL_HI:
            begin
                op_a = {17'd0, cfg.target_mv};
                op_b = {1'b1, cfg.window_fraction};
            end
            MUL_FLO:
            begin
                op_a = lo_num_reg;
                op_b = 17'h10000 - {1'b0, cfg.fast_fraction};
            end
            MUL_FHI:
            begin
                op_a = hi_num_reg;
                op_b = {1'b1, cfg.fast_fraction};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign product = {{MUL_B_W{1'b0}}, op_a} * {{MUL_A_W{1'b0}}, op_b};

    // Scaled sample plus calibration, saturated to 0..65535.
    assign meas_sum = $signed({2'b00, scaled_reg[27:8]})
                    + {{6{cfg.calibration_mv[15]}}, cfg.calibration_mv};

    always_comb
    begin
        if (meas_sum < 0)
        begin
            meas_sat = 16'd0;
        end
        else if (meas_sum > 22'sd65535)
        begin
            meas_sat = 16'hFFFF;
        end
        else
        begin
            meas_sat = meas_sum[15:0];
        end
    end

    // Band decision: fast bands first, then the slow window.
    assign m_wide   = {2'b00, meas_reg, 32'd0};
    assign m_narrow = {1'b0, meas_reg, 16'd0};

    always_comb
    begin
        if (m_wide < fastlo_reg)
        begin
            delta_next = $signed({1'b0, cfg.fast_step});
        end
        else if (m_wide > fasthi_reg)
        begin
            delta_next = -$signed({1'b0, cfg.fast_step});
        end
        else if (m_narrow < lo_num_reg)
        begin
            delta_next = $signed({1'b0, cfg.slow_step});
        end
        else if (m_narrow > hi_num_reg)
        begin
            delta_next = -$signed({1'b0, cfg.slow_step});
        end
        else
        begin
            delta_next = 17'sd0;
        end
    end

    // Step the duty and clamp to max, then to min.
    assign duty_sum = $signed({2'b00, duty_reg}) + {delta_reg[16], delta_reg};

    always_comb
    begin
        duty_clamped = duty_sum;
        if (duty_clamped > $signed({2'b00, cfg.max_duty}))
        begin
            duty_clamped = $signed({2'b00, cfg.max_duty});
        end
        if (duty_clamped < $signed({2'b00, cfg.min_duty}))
        begin
            duty_clamped = $signed({2'b00, cfg.min_duty});
        end
    end

    assign duty_new = duty_clamped[15:0];

    // State update for the finished word.
    always_comb
    begin
        run_next       = run_reg;
        duty_next      = duty_reg;
        applied_next   = applied_reg;
        last_meas_next = last_meas_reg;
        written_next   = 1'b0;
        case (cmd_reg)
            CMD_ADJUST:
            begin
                if (run_reg)
                begin
                    last_meas_next = meas_reg;
                    if (duty_new != duty_reg)
                    begin
                        duty_next    = duty_new;
                        applied_next = duty_new;
                        written_next = 1'b1;
                    end
                end
                else
                begin
                    last_meas_next = 16'd0;
                    duty_next      = 16'd0;
                end
            end
            CMD_START:
            begin
                if (!run_reg)
                begin
                    applied_next = cfg.min_duty;
                    run_next     = 1'b1;
                    written_next = 1'b1;
                end
            end
            CMD_STOP:
            begin
                run_next = 1'b0;
            end
            default:
            begin
                run_next = run_reg;
            end
        endcase
    end

    // Working registers, loaded as the controller commands.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= in_cmd;
            adc_reg <= in_adc_mv;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                MUL_GAIN: scaled_reg <= product[27:0];
                MUL_LO:   lo_num_reg <= product[32:0];
                MUL_HI:   hi_num_reg <= product[32:0];
                MUL_FLO:  fastlo_reg <= product;
                MUL_FHI:  fasthi_reg <= product;
                default:  scaled_reg <= scaled_reg;
            endcase
        end
        if (cmd.load_meas)
        begin
            meas_reg <= meas_sat;
        end
        if (cmd.load_delta)
        begin
            delta_reg <= delta_next;
        end
        if (cmd.commit)
        begin
            out_meas_reg    <= last_meas_next;
            out_duty_reg    <= duty_next;
            out_pwm_reg     <= applied_next;
            out_written_reg <= written_next;
            out_run_reg     <= run_next;
        end
    end

    // Regulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            duty_reg      <= 16'd0;
            applied_reg   <= 16'd0;
            last_meas_reg <= 16'd0;
        end
        else if (cmd.commit)
        begin
            run_reg       <= run_next;
            duty_reg      <= duty_next;
            applied_reg   <= applied_next;
            last_meas_reg <= last_meas_next;
        end
    end

    assign measured_mv  = out_meas_reg;
    assign tracked_duty = out_duty_reg;
    assign pwm_duty     = out_pwm_reg;
    assign duty_written = out_written_reg;
    assign running      = out_run_reg;

endmodule

`default_nettype wire

// ----- sv/dsr_checker.sv -----
// Port-level checks of the duty step regulator and their binding.
`timescale 1ns / 1ps
`default_nettype none

module dsr_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic pready,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic duty_written,
    input wire logic running
);

    // The configuration port never inserts wait states.
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    // A result word stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    // Only one word is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a word is in progress");

    // The PWM is written only by a running converter.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && duty_written |-> running)
        else $error("duty written while stopped");

endmodule

bind dc_dc_duty_step_regulator dsr_checker u_dsr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .duty_written (rsp.duty_written),
    .running      (rsp.running)
);

`default_nettype wire
